[rtl/core/frss_pkg.sv]
`default_nettype none

package frss_pkg;

    // Opcodes of an input word
    localparam logic OP_BEGIN  = 1'b0;
    localparam logic OP_COMMIT = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUD_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_SEC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_MASK = 2'd2;
    localparam int CFG_DATA_W = 32;

    // Configuration reset values
    localparam logic [31:0] HUD_PERIOD_RST = 32'd60;
    localparam logic [31:0] TICKS_SEC_RST  = 32'd60;
    localparam logic [7:0]  LAYER_MASK_RST = 8'd7;

    // All-ones tick mark: anchor or metric tick not yet set
    localparam logic [31:0] TICK_UNSET = 32'hFFFF_FFFF;
    localparam logic [31:0] GEN_RST    = 32'hFFFF_FFFF;

    // Vertical scroll sits at this value for level pitch
    localparam logic [9:0] SCROLL_CENTER = 10'd128;

    // Width of the serial divider
    localparam int DIV_W   = 32;
    localparam int DIV_CNT = $clog2(DIV_W);

    typedef struct packed {
        logic        op;
        logic        has_snapshot;
        logic        snapshot_valid;
        logic [15:0] yaw;
        logic signed [15:0] pitch;
        logic [31:0] snapshot_generation;
        logic        has_generations;
        logic [31:0] displayed_gen;
        logic [31:0] rendered_gen;
        logic [31:0] simulated_gen;
        logic [31:0] tick_now;
    } in_word_t;

    typedef struct packed {
        logic        frame_prepared;
        logic [8:0]  scroll_x;
        logic [8:0]  scroll_y;
        logic [31:0] frames_per_second;
        logic        hud_refresh;
        logic        committed;
        logic        text_rewrite;
        logic [7:0]  layers_out;
        logic [31:0] commit_total;
    } out_word_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/core/frss_if.sv]
`default_nettype none

interface frss_in_if;
    import frss_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface frss_out_if;
    import frss_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/frss_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module frss_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire frss_pkg::div_ctrl_t         ctrl,
    input  wire logic [frss_pkg::DIV_W-1:0]  dividend,
    input  wire logic [frss_pkg::DIV_W-1:0]  divisor,
    output frss_pkg::div_stat_t              stat,
    output logic [frss_pkg::DIV_W-1:0]       quotient
);
    import frss_pkg::*;

    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DIV_W:0] rem_shift;
    logic [DIV_W:0] diff;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // subtract when the shifted remainder covers the divisor
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

[rtl/core/frame_rate_meter_and_scroll_shadow.sv]
// Sequence: an accepted input word is captured, evaluated and its result registered;
//   a rate recomputation adds the multiply, the divider start, 32 divider steps and done.
// Throughput: one word at a time; the next input is taken once the result is
//   registered, so an output stall also holds back the next input.
// Reset (rst_n, async, active low): all state to its reset values, config to
//   period 60, ticks per second 60, layer mask 7; no clearing pass is needed.
`default_nettype none

module frame_rate_meter_and_scroll_shadow (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    frss_in_if.sink                                 in_ch,
    frss_out_if.source                              out_ch,
    input  wire logic                               cfg_we,
    input  wire logic [frss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [frss_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import frss_pkg::*;

    // Sequencer: take a word, evaluate it in one pass, then, if the rate is due over
    // nonzero elapsed ticks, form frames * ticks_per_second for the serial divider.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [31:0] period_reg;
    logic [31:0] tps_reg;
    logic [7:0]  mask_reg;

    // Captured input word
    in_word_t in_reg, in_next;

    // Block state
    logic [8:0]  sky_x_reg, sky_x_next;
    logic [8:0]  sky_y_reg, sky_y_next;
    logic [31:0] anchor_reg, anchor_next;
    logic [31:0] fc_reg, fc_next;
    logic [31:0] fps_reg, fps_next;
    logic [31:0] last_metric_reg, last_metric_next;
    logic [31:0] seen_reg [3];
    logic [31:0] seen_next [3];
    logic        pending_reg, pending_next;
    logic        rdy_flag_reg, rdy_flag_next;
    logic [31:0] commit_cnt_reg, commit_cnt_next;

    // Divide operands and per-word result flags
    logic [31:0] prod_reg, prod_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        prepared_reg, prepared_next;
    logic        refresh_reg, refresh_next;
    logic        committed_reg, committed_next;
    logic        text_rewrite_reg, text_rewrite_next;
    logic [7:0]  layers_reg, layers_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;

    // Serial divider
    div_ctrl_t   div_ctrl;
    div_stat_t   div_stat;
    logic [31:0] div_quo;

    // Decode of the captured word
    logic        gens_ok;
    logic        accept;
    logic        restart;
    logic        due;
    logic        changed;
    logic [31:0] tick_delta;
    logic [31:0] anchor_delta;
    logic [8:0]  scroll_y_calc;

    frss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (prod_reg),
        .divisor  (elapsed_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= HUD_PERIOD_RST;
            tps_reg    <= TICKS_SEC_RST;
            mask_reg   <= LAYER_MASK_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HUD_PERIOD)
            begin
                period_reg <= cfg_data;
            end
            else if (cfg_index == CFG_TICKS_SEC)
            begin
                tps_reg <= cfg_data;
            end
            else if (cfg_index == CFG_LAYER_MASK)
            begin
                mask_reg <= cfg_data[7:0];
            end
        end
    end

    // A frame with generations must agree with its snapshot and be nonzero.
    assign gens_ok = (in_reg.displayed_gen != '0)
                  && (in_reg.displayed_gen == in_reg.rendered_gen)
                  && (in_reg.snapshot_generation == in_reg.displayed_gen)
                  && (in_reg.simulated_gen != '0);
    assign accept  = (in_reg.has_snapshot == in_reg.has_generations)
                  && (!in_reg.has_generations || gens_ok);

    // Anchor restarts when unset or when the tick runs backwards.
    assign restart      = (anchor_reg == TICK_UNSET) || (in_reg.tick_now < anchor_reg);
    assign tick_delta   = in_reg.tick_now - last_metric_reg;
    assign anchor_delta = in_reg.tick_now - anchor_reg;
    assign due          = (last_metric_reg == TICK_UNSET)
                       || (in_reg.tick_now < last_metric_reg)
                       || (tick_delta >= period_reg);
    assign changed      = in_reg.has_generations
                       && ((seen_reg[0] != in_reg.displayed_gen)
                        || (seen_reg[1] != in_reg.rendered_gen)
                        || (seen_reg[2] != in_reg.simulated_gen));

    // 128 plus the signed top byte of pitch always lands in 0..255,
    // so the 0..256 clamp never bites.
    assign scroll_y_calc = 9'(SCROLL_CENTER
                            + {{2{in_reg.pitch[15]}}, in_reg.pitch[15:8]});

    always_comb
    begin
        state_next        = state_reg;
        in_next           = in_reg;
        sky_x_next        = sky_x_reg;
        sky_y_next        = sky_y_reg;
        anchor_next       = anchor_reg;
        fc_next           = fc_reg;
        fps_next          = fps_reg;
        last_metric_next  = last_metric_reg;
        seen_next         = seen_reg;
        pending_next      = pending_reg;
        rdy_flag_next     = rdy_flag_reg;
        commit_cnt_next   = commit_cnt_reg;
        prod_next         = prod_reg;
        elapsed_next      = elapsed_reg;
        prepared_next     = prepared_reg;
        refresh_next      = refresh_reg;
        committed_next    = committed_reg;
        text_rewrite_next = text_rewrite_reg;
        layers_next       = layers_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg;
        div_ctrl.start    = 1'b0;

        // Drop the result once the sink takes it.
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    in_next    = in_ch.payload;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                prepared_next     = 1'b0;
                refresh_next      = 1'b0;
                committed_next    = 1'b0;
                text_rewrite_next = 1'b0;
                layers_next       = '0;
                state_next        = S_FIN;
                if (in_reg.op == OP_BEGIN)
                begin
                    rdy_flag_next = 1'b0;
                    if (accept)
                    begin
                        if (in_reg.has_snapshot && in_reg.snapshot_valid)
                        begin
                            sky_x_next = in_reg.yaw[15:7];
                            sky_y_next = scroll_y_calc;
                        end
                        if (restart)
                        begin
                            anchor_next = in_reg.tick_now;
                            fc_next     = 32'd1;
                            fps_next    = '0;
                        end
                        else
                        begin
                            fc_next = fc_reg + 32'd1;
                        end
                        if (due || changed)
                        begin
                            if (due)
                            begin
                                // Skip the divide on a fresh anchor or zero elapsed; the rate stands.
                                if (!restart && (anchor_delta != '0))
                                begin
                                    elapsed_next = anchor_delta;
                                    state_next   = S_MUL;
                                end
                                last_metric_next = in_reg.tick_now;
                            end
                            if (in_reg.has_generations)
                            begin
                                seen_next[0] = in_reg.displayed_gen;
                                seen_next[1] = in_reg.rendered_gen;
                                seen_next[2] = in_reg.simulated_gen;
                            end
                            pending_next = 1'b1;
                            refresh_next = 1'b1;
                        end
                        rdy_flag_next = 1'b1;
                        prepared_next = 1'b1;
                    end
                end
                else if (rdy_flag_reg)
                begin
                    committed_next    = 1'b1;
                    text_rewrite_next = pending_reg;
                    layers_next       = mask_reg;
                    pending_next      = 1'b0;
                    rdy_flag_next     = 1'b0;
                    commit_cnt_next   = commit_cnt_reg + 32'd1;
                end
            end

            S_MUL:
            begin
                // Product wraps at 32 bits.
                prod_next  = fc_reg * tps_reg;
                state_next = S_DSTART;
            end

            S_DSTART:
            begin
                div_ctrl.start = 1'b1;
                state_next     = S_DIV;
            end

            S_DIV:
            begin
                if (div_stat.done)
                begin
                    fps_next    = div_quo;
                    anchor_next = in_reg.tick_now;
                    fc_next     = '0;
                    state_next  = S_FIN;
                end
            end

            S_FIN:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next.frame_prepared    = prepared_reg;
                    out_next.scroll_x          = sky_x_reg;
                    out_next.scroll_y          = sky_y_reg;
                    out_next.frames_per_second = fps_reg;
                    out_next.hud_refresh       = refresh_reg;
                    out_next.committed         = committed_reg;
                    out_next.text_rewrite      = text_rewrite_reg;
                    out_next.layers_out        = layers_reg;
                    out_next.commit_total      = commit_cnt_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            in_reg           <= '0;
            sky_x_reg        <= '0;
            sky_y_reg        <= '0;
            anchor_reg       <= TICK_UNSET;
            fc_reg           <= '0;
            fps_reg          <= '0;
            last_metric_reg  <= TICK_UNSET;
            seen_reg[0]      <= GEN_RST;
            seen_reg[1]      <= GEN_RST;
            seen_reg[2]      <= GEN_RST;
            pending_reg      <= 1'b0;
            rdy_flag_reg     <= 1'b0;
            commit_cnt_reg   <= '0;
            prod_reg         <= '0;
            elapsed_reg      <= '0;
            prepared_reg     <= 1'b0;
            refresh_reg      <= 1'b0;
            committed_reg    <= 1'b0;
            text_rewrite_reg <= 1'b0;
            layers_reg       <= '0;
            out_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            in_reg           <= in_next;
            sky_x_reg        <= sky_x_next;
            sky_y_reg        <= sky_y_next;
            anchor_reg       <= anchor_next;
            fc_reg           <= fc_next;
            fps_reg          <= fps_next;
            last_metric_reg  <= last_metric_next;
            seen_reg         <= seen_next;
            pending_reg      <= pending_next;
            rdy_flag_reg     <= rdy_flag_next;
            commit_cnt_reg   <= commit_cnt_next;
            prod_reg         <= prod_next;
            elapsed_reg      <= elapsed_next;
            prepared_reg     <= prepared_next;
            refresh_reg      <= refresh_next;
            committed_reg    <= committed_next;
            text_rewrite_reg <= text_rewrite_next;
            layers_reg       <= layers_next;
            out_reg          <= out_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

`ifndef SYNTHESIS
    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide wait");

    // A started divide is running on the next cycle, never with a zero divisor.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSTART) |=> (div_stat.busy && (elapsed_reg != '0)))
        else $error("divide start lost or zero divisor");

    // A commit result never also reports a prepared or refreshed frame.
    a_commit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.committed)
            |-> (!out_reg.frame_prepared && !out_reg.hud_refresh))
        else $error("commit result mixed with begin flags");
`endif

endmodule

`default_nettype wire

[tb/frame_rate_meter_and_scroll_shadow_tb.sv]
`default_nettype none

module frame_rate_meter_and_scroll_shadow_tb;
    import frss_pkg::*;

    // Cycles to let pass once nothing is expected: covers the longest divide.
    localparam int DRAIN_CYCLES = 40;
    // Hard stop, several times the slowest legal run of 1774 words.
    localparam int RUN_LIMIT = 8_000_000;
    // Chance, in percent, that a side sits out a cycle.
    localparam int IDLE_PCT = 38;

    // Ways to break an otherwise good begin word.
    typedef enum int {
        DROP_GENS,
        DROP_SNAPSHOT,
        ZERO_DISPLAYED,
        SKEW_RENDERED,
        SKEW_SNAPSHOT,
        ZERO_SIMULATED
    } spoil_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frss_in_if  in_ch();
    frss_out_if out_ch();

    frame_rate_meter_and_scroll_shadow DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration, kept in step with every register write.
    logic [31:0] cfg_period = HUD_PERIOD_RST;
    logic [31:0] cfg_tps    = TICKS_SEC_RST;
    logic [7:0]  cfg_layers = LAYER_MASK_RST;

    // Shadow copy of the meter state.
    logic [8:0]  shadow_x     = '0;
    logic [8:0]  shadow_y     = '0;
    logic [31:0] anchor_mark  = TICK_UNSET;
    logic [31:0] frames_seen  = '0;
    logic [31:0] rate_now     = '0;
    logic [31:0] metric_mark  = TICK_UNSET;
    logic [31:0] gen_seen [3] = '{GEN_RST, GEN_RST, GEN_RST};
    logic        refresh_owed = 1'b0;
    logic        frame_armed  = 1'b0;
    logic [31:0] commits_done = '0;

    // Result words still owed by the block, oldest first.
    out_word_t meter_words_due[$];

    int          mismatches  = 0;
    bit          steady      = 1'b0;   // suppress idling on both sides
    logic [31:0] tick_clock  = 32'd1000;
    int unsigned tick_stride = 40;
    logic [31:0] live_gen    = 32'd1;

    // 100 MHz-style clock, period 10.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Work out the result word for one accepted input word and advance the shadow state.
    function automatic out_word_t advance_meter(input in_word_t w);
        out_word_t   r;
        logic        accept;
        logic        due;
        logic        changed;
        logic [31:0] elapsed;
        logic [31:0] product;
        logic signed [7:0] pitch_hi;
        int          y;
        r = '0;
        if (w.op == OP_BEGIN)
        begin
            frame_armed = 1'b0;
            accept = (w.has_snapshot == w.has_generations) &&
                     (!w.has_generations ||
                      (w.displayed_gen != '0 && w.displayed_gen == w.rendered_gen &&
                       w.snapshot_generation == w.displayed_gen &&
                       w.simulated_gen != '0));
            if (accept)
            begin
                // Camera angles move the sky only when they come with a valid snapshot.
                if (w.has_snapshot && w.snapshot_valid)
                begin
                    shadow_x = w.yaw[15:7];
                    pitch_hi = w.pitch[15:8];
                    y = 128 + pitch_hi;
                    if (y < 0)
                        y = 0;
                    else if (y > 256)
                        y = 256;
                    shadow_y = y[8:0];
                end
                // Restart the anchor when unset or when time runs backwards.
                if (anchor_mark == TICK_UNSET || w.tick_now < anchor_mark)
                begin
                    anchor_mark = w.tick_now;
                    frames_seen = 32'd1;
                    rate_now = '0;
                end
                else
                begin
                    frames_seen = frames_seen + 32'd1;
                end
                due = metric_mark == TICK_UNSET || w.tick_now < metric_mark ||
                      (w.tick_now - metric_mark) >= cfg_period;
                changed = w.has_generations &&
                          (gen_seen[0] != w.displayed_gen || gen_seen[1] != w.rendered_gen ||
                           gen_seen[2] != w.simulated_gen);
                if (due || changed)
                begin
                    if (due)
                    begin
                        // Hold the anchor and the old rate when no tick has passed.
                        elapsed = w.tick_now - anchor_mark;
                        if (elapsed != '0)
                        begin
                            product = frames_seen * cfg_tps;
                            rate_now = product / elapsed;
                            anchor_mark = w.tick_now;
                            frames_seen = '0;
                        end
                        metric_mark = w.tick_now;
                    end
                    if (w.has_generations)
                    begin
                        gen_seen[0] = w.displayed_gen;
                        gen_seen[1] = w.rendered_gen;
                        gen_seen[2] = w.simulated_gen;
                    end
                    refresh_owed = 1'b1;
                    r.hud_refresh = 1'b1;
                end
                frame_armed = 1'b1;
                r.frame_prepared = 1'b1;
            end
        end
        else if (frame_armed)
        begin
            r.committed = 1'b1;
            r.text_rewrite = refresh_owed;
            r.layers_out = cfg_layers;
            refresh_owed = 1'b0;
            frame_armed = 1'b0;
            commits_done = commits_done + 32'd1;
        end
        r.scroll_x = shadow_x;
        r.scroll_y = shadow_y;
        r.frames_per_second = rate_now;
        r.commit_total = commits_done;
        return r;
    endfunction

    function automatic logic [31:0] nonzero32();
        logic [31:0] v;
        do
            v = $urandom;
        while (v == '0);
        return v;
    endfunction

    // Every field random: the base of all other words.
    function automatic in_word_t noise_word();
        in_word_t w;
        w.op = 1'($urandom);
        w.has_snapshot = 1'($urandom);
        w.snapshot_valid = 1'($urandom);
        w.yaw = 16'($urandom);
        w.pitch = 16'($urandom);
        w.snapshot_generation = $urandom;
        w.has_generations = 1'($urandom);
        w.displayed_gen = $urandom;
        w.rendered_gen = $urandom;
        w.simulated_gen = $urandom;
        w.tick_now = $urandom;
        return w;
    endfunction

    // A begin word whose snapshot and generation counters agree; gen must be nonzero.
    function automatic in_word_t camera_begin(input logic [31:0] tick, input logic [31:0] gen);
        in_word_t w;
        w = noise_word();
        w.op = OP_BEGIN;
        w.has_snapshot = 1'b1;
        w.has_generations = 1'b1;
        w.snapshot_valid = ($urandom_range(0, 4) != 0);
        w.snapshot_generation = gen;
        w.displayed_gen = gen;
        w.rendered_gen = gen;
        w.simulated_gen = nonzero32();
        w.tick_now = tick;
        return w;
    endfunction

    // A begin word with neither snapshot nor generations: always accepted.
    function automatic in_word_t bare_begin(input logic [31:0] tick);
        in_word_t w;
        w = noise_word();
        w.op = OP_BEGIN;
        w.has_snapshot = 1'b0;
        w.has_generations = 1'b0;
        w.tick_now = tick;
        return w;
    endfunction

    function automatic in_word_t commit_word();
        in_word_t w;
        w = noise_word();
        w.op = OP_COMMIT;
        return w;
    endfunction

    // Break exactly one of the agreement rules of a good begin word.
    function automatic in_word_t spoil_begin(input in_word_t w, input spoil_t how);
        case (how)
            DROP_GENS:      w.has_generations = 1'b0;
            DROP_SNAPSHOT:  w.has_snapshot = 1'b0;
            ZERO_DISPLAYED:
            begin
                w.displayed_gen = '0;
                w.rendered_gen = '0;
                w.snapshot_generation = '0;
            end
            SKEW_RENDERED:  w.rendered_gen = w.rendered_gen ^ nonzero32();
            SKEW_SNAPSHOT:  w.snapshot_generation = w.snapshot_generation ^ nonzero32();
            ZERO_SIMULATED: w.simulated_gen = '0;
            default:        ;
        endcase
        return w;
    endfunction

    // Advance the source tick: mostly forward steps, now and then a jump anywhere
    // (often backwards) or straight onto the unset mark.
    function automatic logic [31:0] next_tick();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            tick_clock = $urandom;
        else if (pick == 3)
            tick_clock = TICK_UNSET;
        else
            tick_clock = tick_clock + $urandom_range(0, tick_stride);
        return tick_clock;
    endfunction

    // Offer one word, idling at random first, and book its result once taken.
    task automatic send_word(input in_word_t w);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        meter_words_due.push_back(advance_meter(w));
    endtask

    // Drop valid and wait until every owed word is back and the divider is quiet.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (meter_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HUD_PERIOD: cfg_period = val;
            CFG_TICKS_SEC:  cfg_tps = val;
            CFG_LAYER_MASK: cfg_layers = val[7:0];
            default:        ;
        endcase
    endtask

    // Mostly well-formed begin/commit traffic, with broken begins and pure noise mixed in.
    task automatic run_traffic(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0)
                live_gen = nonzero32();
            if (pick < 45)
                send_word(camera_begin(next_tick(), live_gen));
            else if (pick < 55)
                send_word(bare_begin(next_tick()));
            else if (pick < 85)
                send_word(commit_word());
            else if (pick < 93)
                send_word(spoil_begin(camera_begin(next_tick(), live_gen),
                                      spoil_t'($urandom_range(0, 5))));
            else
                send_word(noise_word());
        end
    endtask

    // Walk through the corner cases by hand, starting from reset values.
    task automatic test_opening_sequence();
        in_word_t w;
        int k;
        send_word(commit_word());              // commit with nothing prepared
        send_word(bare_begin(32'd100));        // both marks unset: due, zero elapsed
        send_word(commit_word());              // hands out the refresh
        send_word(commit_word());              // second commit finds nothing
        w = camera_begin(32'd110, 32'd5);      // generations change, metrics not due
        w.yaw = 16'hFFFF;
        w.pitch = 16'sh8000;
        w.snapshot_valid = 1'b1;
        send_word(w);
        send_word(commit_word());
        w = camera_begin(32'd170, 32'd5);      // period passed: rate recomputed
        w.yaw = 16'h0000;
        w.pitch = 16'sh7FFF;
        w.snapshot_valid = 1'b1;
        send_word(w);
        w = camera_begin(32'd175, 32'd5);      // snapshot present but not valid
        w.snapshot_valid = 1'b0;
        send_word(w);
        for (k = 0; k < 6; k++)
            send_word(spoil_begin(camera_begin(32'd176, 32'd5), spoil_t'(k)));
        send_word(commit_word());              // rejection cleared the prepared frame
        w = camera_begin(32'd180, 32'hFFFF_FFFF);
        w.simulated_gen = 32'hFFFF_FFFF;
        send_word(w);
        w.tick_now = 32'd181;                  // same generations again: no refresh
        send_word(w);
        send_word(bare_begin(32'd50));         // tick runs backwards
        send_word(bare_begin(32'd50));         // no tick passed since the anchor
        send_word(bare_begin(TICK_UNSET));     // all-ones tick lands on the unset mark
        send_word(bare_begin(32'd10));
        send_word(commit_word());
        w = camera_begin(32'd80, 32'd9);
        w.yaw = 16'h8000;
        w.pitch = 16'sh0000;
        w.snapshot_valid = 1'b1;
        send_word(w);
        send_word(commit_word());
    endtask

    // Near both ends of every register: period 1 with a wrapping product, then
    // the longest period with a scale of 1 and an empty mask.
    task automatic test_register_extremes();
        wait_idle();
        write_reg(CFG_HUD_PERIOD, 32'd1);
        write_reg(CFG_TICKS_SEC, 32'hFFFF_FFFF);
        write_reg(CFG_LAYER_MASK, 32'h0000_00FF);
        tick_stride = 3;
        run_traffic(50);
        wait_idle();
        write_reg(CFG_HUD_PERIOD, 32'hFFFF_FFFF);
        write_reg(CFG_TICKS_SEC, 32'd1);
        write_reg(CFG_LAYER_MASK, 32'h0000_0000);
        tick_stride = 500;
        run_traffic(50);
    endtask

    // Random settings per phase; one phase runs with no idling on either side.
    task automatic test_random_phases();
        int p;
        logic [31:0] period;
        logic [31:0] scale;
        for (p = 0; p < 6; p++)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       period = $urandom_range(1, 8);
                1:       period = $urandom_range(20, 200);
                2:       period = nonzero32();
                default: period = HUD_PERIOD_RST;
            endcase
            scale = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 120)) : nonzero32();
            write_reg(CFG_HUD_PERIOD, period);
            write_reg(CFG_TICKS_SEC, scale);
            write_reg(CFG_LAYER_MASK, 32'($urandom_range(0, 255)));
            // Short periods: steps near the period so the rate is recomputed often.
            tick_stride = (period <= 200) ? 2 * period + 2 : $urandom_range(1, 1000);
            steady = (p == 2);
            run_traffic(275);
        end
        steady = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // Receiver: stall at random, except during the steady stretch.
    always @(negedge clk)
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Check every accepted result word against the oldest owed word.
    always @(posedge clk)
    begin : word_check
        out_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (meter_words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing owed: %h", $realtime, out_ch.payload);
            end
            else
            begin
                want = meter_words_due.pop_front();
                compare_field("frame_prepared", want.frame_prepared, out_ch.payload.frame_prepared);
                compare_field("scroll_x", want.scroll_x, out_ch.payload.scroll_x);
                compare_field("scroll_y", want.scroll_y, out_ch.payload.scroll_y);
                compare_field("frames_per_second", want.frames_per_second,
                              out_ch.payload.frames_per_second);
                compare_field("hud_refresh", want.hud_refresh, out_ch.payload.hud_refresh);
                compare_field("committed", want.committed, out_ch.payload.committed);
                compare_field("text_rewrite", want.text_rewrite, out_ch.payload.text_rewrite);
                compare_field("layers_out", want.layers_out, out_ch.payload.layers_out);
                compare_field("commit_total", want.commit_total, out_ch.payload.commit_total);
            end
        end
    end

    initial
    begin
        // Hold every input at a known value from time zero, reset asserted.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_opening_sequence();
        test_register_extremes();
        test_random_phases();
        wait_idle();

        if (mismatches == 0 && meter_words_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #RUN_LIMIT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/core/frss_pkg.sv
rtl/core/frss_if.sv
rtl/core/frss_div.sv
rtl/core/frame_rate_meter_and_scroll_shadow.sv
tb/frame_rate_meter_and_scroll_shadow_tb.sv
